[hw/rtl/rde_pkg.sv]
package rde_pkg;

  localparam int unsigned VALUE_WIDTH = 31;
  localparam int unsigned DIGIT_WIDTH = 5;
  localparam int unsigned CHAR_WIDTH  = 7;
  localparam int unsigned CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned IDX_WIDTH   = $clog2(VALUE_WIDTH);
  localparam int unsigned IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int unsigned OUT_FIELD_W = DIGIT_WIDTH + CHAR_WIDTH;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic RegRadix = 1'b0;

  localparam logic [DIGIT_WIDTH-1:0] RadixMin   = 5'd2;
  localparam logic [DIGIT_WIDTH-1:0] RadixMax   = 5'd20;
  localparam logic [DIGIT_WIDTH-1:0] RadixReset = 5'd10;
  localparam logic [DIGIT_WIDTH-1:0] DecimalLim = 5'd10;
  localparam logic [CHAR_WIDTH-1:0]  LetterOffs = 7'd55;
  localparam logic [CHAR_WIDTH-1:0]  ZeroChar   = 7'd48;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [DIGIT_WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                   busy;
    logic                   done;
    logic [VALUE_WIDTH-1:0] quot;
    logic [DIGIT_WIDTH-1:0] rem;
  } div_res_t;

  function automatic logic [DIGIT_WIDTH-1:0] eff_radix(input logic [DIGIT_WIDTH-1:0] r);
    logic [DIGIT_WIDTH-1:0] res;
    res = r;
    if (r < RadixMin) begin
      res = RadixMin;
    end else if (r > RadixMax) begin
      res = RadixMax;
    end
    return res;
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] char_of(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] res;
    if (d >= DecimalLim) begin
      res = LetterOffs + CHAR_WIDTH'(d);
    end else begin
      res = ZeroChar + CHAR_WIDTH'(d);
    end
    return res;
  endfunction

endpackage

[hw/rtl/rde_divider.sv]
module rde_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rde_pkg::div_req_t req_i,
  output rde_pkg::div_res_t res_o
);

  localparam int unsigned W  = rde_pkg::VALUE_WIDTH;
  localparam int unsigned DW = rde_pkg::DIGIT_WIDTH;
  localparam int unsigned IW = rde_pkg::IDX_WIDTH;

  logic [W-1:0]  quot_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] divisor_q;
  logic [IW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // One quotient bit per cycle, restoring division.
  always_comb begin
    trial = {rem_q, quot_q[W-1]};
    ge    = trial >= {1'b0, divisor_q};
    diff  = trial - {1'b0, divisor_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + IW'(1);
      if (cnt_q == IW'(W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quot_q    <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quot_q <= {quot_q[W-2:0], ge};
      rem_q  <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign res_o.busy = busy_q;
  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

[hw/rtl/radix_digit_emitter.sv]
// Channel  | Direction | Handshake               | Payload
// s_axis   | in        | s_axis_tvalid/tready    | tdata: value
// m_axis   | out       | m_axis_tvalid/tready    | tdata: digit_value, digit_char; tlast: last
// apb      | in        | psel/penable/pready     | paddr[2]=0: radix
//
// Each digit comes from the bit-serial divider, which yields one quotient bit per cycle.
// An input word of n digits takes one division per digit, then its n digits are emitted.
// Digits leave most significant first through an output register.
// The input side is ready again once the last digit has been loaded into that register.
// Reset restores radix 10 and clears all control state.
module radix_digit_emitter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [30:0] value
  input  logic [rde_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [4:0] digit_value, [11:5] digit_char
  output logic [rde_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rde_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rde_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rde_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned W  = rde_pkg::VALUE_WIDTH;
  localparam int unsigned DW = rde_pkg::DIGIT_WIDTH;
  localparam int unsigned CW = rde_pkg::CNT_WIDTH;
  localparam int unsigned IW = rde_pkg::IDX_WIDTH;

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StEmit
  } state_e;

  state_e        state_q, state_d;
  logic [DW-1:0] radix_q, radix_d;
  logic [DW-1:0] base_q, base_d;
  logic [W-1:0]  quot_q, quot_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          start_q, start_d;
  logic          mvalid_q, mvalid_d;
  logic [DW-1:0] odigit_q, odigit_d;
  logic          olast_q, olast_d;

  logic [DW-1:0] store_q [W];

  rde_pkg::div_req_t div_req;
  rde_pkg::div_res_t div_res;

  logic          s_hs;
  logic          cfg_wr;
  logic          out_free;
  logic [CW-1:0] cnt_inc;

  assign pready        = 1'b1;
  assign prdata        = rde_pkg::APB_DATA_W'(radix_q);
  assign cfg_wr        = psel && penable && pwrite && pready
                         && (paddr[2] == rde_pkg::RegRadix);
  assign s_axis_tready = (state_q == StIdle);
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign out_free      = !mvalid_q || m_axis_tready;
  assign cnt_inc       = cnt_q + CW'(1);

  assign div_req.start    = start_q;
  assign div_req.dividend = quot_q;
  assign div_req.divisor  = base_q;

  rde_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  always_comb begin
    state_d  = state_q;
    radix_d  = radix_q;
    base_d   = base_q;
    quot_d   = quot_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    start_d  = 1'b0;
    mvalid_d = mvalid_q && !m_axis_tready;
    odigit_d = odigit_q;
    olast_d  = olast_q;

    if (cfg_wr) begin
      radix_d = pwdata[DW-1:0];
    end

    unique case (state_q)
      StIdle: begin
        if (s_hs) begin
          quot_d  = s_axis_tdata[W-1:0];
          base_d  = rde_pkg::eff_radix(radix_q);
          cnt_d   = '0;
          start_d = 1'b1;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_res.done) begin
          quot_d = div_res.quot;
          cnt_d  = cnt_inc;
          if ((div_res.quot != '0) && (cnt_inc < CW'(W))) begin
            start_d = 1'b1;
          end else begin
            idx_d   = cnt_q[IW-1:0];
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          odigit_d = store_q[idx_q];
          olast_d  = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q - IW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      radix_q  <= rde_pkg::RadixReset;
      base_q   <= rde_pkg::RadixReset;
      quot_q   <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      start_q  <= 1'b0;
      mvalid_q <= 1'b0;
      odigit_q <= '0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      radix_q  <= radix_d;
      base_q   <= base_d;
      quot_q   <= quot_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      start_q  <= start_d;
      mvalid_q <= mvalid_d;
      odigit_q <= odigit_d;
      olast_q  <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StDiv) && div_res.done) begin
      store_q[cnt_q[IW-1:0]] <= div_res.rem;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = rde_pkg::OUT_TDATA_W'({rde_pkg::char_of(odigit_q), odigit_q});

  a_start_idle_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> !div_res.busy)
    else $error("divider started while busy");

  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == StDiv))
    else $error("divider result outside division phase");

  a_emit_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (CW'(idx_q) < cnt_q))
    else $error("emit index beyond stored digits");

  a_digit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (odigit_q < base_q))
    else $error("digit not below radix");

endmodule
